FILE: hdl/xbr_pkg.sv
// ----------------------------------------------------------------------------
// xbr_pkg: shared types and constants for the bounded random number block
// Actions, output selects, controller states, command and status bundles,
// shift and rotate amounts of both generators, remainder step function.
// ----------------------------------------------------------------------------
package xbr_pkg;

	localparam int WORD_W = 64;
	localparam int MIN_W  = 32;
	localparam int CNT_W  = 6;

	// xorshift128+ shifts
	localparam int XS_A = 23;
	localparam int XS_B = 18;
	localparam int XS_C = 5;

	// xoroshiro128+ rotate, shift, rotate
	localparam int XO_A = 24;
	localparam int XO_B = 16;
	localparam int XO_C = 37;

	// configuration register indexes
	localparam logic REG_SEED_LOW  = 1'b0;
	localparam logic REG_SEED_HIGH = 1'b1;

	typedef enum logic [1:0] {
		ACT_XORSHIFT  = 2'd0,
		ACT_XOROSHIRO = 2'd1,
		ACT_ROLL      = 2'd2,
		ACT_NONE      = 2'd3
	} xbr_action_t;

	typedef enum logic [2:0] {
		OSEL_XS,
		OSEL_XO,
		OSEL_ROLL,
		OSEL_ZERO,
		OSEL_BAD
	} xbr_osel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK
	} xbr_state_t;

	// controller to datapath
	typedef struct packed {
		logic      gen_xs;    // step state as xorshift128+
		logic      gen_xo;    // step state as xoroshiro128+
		logic      latch_req; // capture possibilities and minimum
		logic      draw;      // xoroshiro step, capture roll, clear divider
		logic      div_run;   // one remainder step on both units
		logic      out_load;  // write the result register
		xbr_osel_t out_sel;
	} xbr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic p_zero;   // incoming possibilities is zero
		logic div_last; // final remainder step this cycle
		logic reject;   // roll lies above the acceptance limit
	} xbr_status_t;

	// one restoring remainder step: shift in a bit, subtract when it fits
	function automatic logic [WORD_W-1:0] rem_step(input logic [WORD_W-1:0] rem,
			input logic bit_in, input logic [WORD_W-1:0] dvsr);
		logic [WORD_W:0] cand;
		logic [WORD_W:0] diff;
		cand = {rem, bit_in};
		diff = cand - {1'b0, dvsr};
		if (cand >= {1'b0, dvsr}) begin
			rem_step = diff[WORD_W-1:0];
		end else begin
			rem_step = cand[WORD_W-1:0];
		end
	endfunction

endpackage

FILE: hdl/xbr_ctrl.sv
// ----------------------------------------------------------------------------
// xbr_ctrl: request sequencer
// Decodes the action, runs the roll loop (draw, divide, check, redraw)
// and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module xbr_ctrl
	import xbr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  xbr_action_t action,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  xbr_status_t status,
	output xbr_cmd_t    cmd
);

	xbr_state_t state_q;
	xbr_state_t state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		cmd       = '0;
		cmd.out_sel = OSEL_ZERO;
		case (state_q)
			ST_IDLE: begin
				s_tready = out_free;
				if (s_tvalid && out_free) begin
					case (action)
						ACT_XORSHIFT: begin
							cmd.gen_xs   = 1'b1;
							cmd.out_load = 1'b1;
							cmd.out_sel  = OSEL_XS;
						end
						ACT_XOROSHIRO: begin
							cmd.gen_xo   = 1'b1;
							cmd.out_load = 1'b1;
							cmd.out_sel  = OSEL_XO;
						end
						ACT_ROLL: begin
							cmd.latch_req = 1'b1;
							if (status.p_zero) begin
								cmd.out_load = 1'b1;
								cmd.out_sel  = OSEL_BAD;
							end else begin
								cmd.draw  = 1'b1;
								state_nxt = ST_DIV;
							end
						end
						default: begin
							cmd.out_load = 1'b1;
							cmd.out_sel  = OSEL_ZERO;
						end
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_run = 1'b1;
				if (status.div_last) begin
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.reject) begin
					cmd.draw  = 1'b1;
					state_nxt = ST_DIV;
				end else if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OSEL_ROLL;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/xbr_dp.sv
// ----------------------------------------------------------------------------
// xbr_dp: generator state, remainder units and result register
// Holds the two state words, both generator steps, two bit-serial
// remainder units (ceiling and roll) and the result payload.
// ----------------------------------------------------------------------------
module xbr_dp
	import xbr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  xbr_cmd_t          cmd,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [WORD_W-1:0] cfg_data,
	input  logic [WORD_W-1:0] possibilities,
	input  logic [MIN_W-1:0]  minimum,
	output xbr_status_t       status,
	output logic [WORD_W-1:0] value,
	output logic              bad_request
);

	logic [WORD_W-1:0] word0_q;
	logic [WORD_W-1:0] word1_q;
	logic [WORD_W-1:0] poss_q;
	logic [MIN_W-1:0]  min_q;
	logic [WORD_W-1:0] roll_q;
	logic [WORD_W-1:0] rem_c_q;
	logic [WORD_W-1:0] rem_r_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] value_q;
	logic              bad_q;

	logic [WORD_W-1:0] xs_a1;
	logic [WORD_W-1:0] xs_w0;
	logic [WORD_W-1:0] xs_w1;
	logic [WORD_W-1:0] xs_sum;
	logic [WORD_W-1:0] xo_b1;
	logic [WORD_W-1:0] xo_w0;
	logic [WORD_W-1:0] xo_w1;
	logic [WORD_W-1:0] xo_sum;
	logic [WORD_W-1:0] offset;

	// xorshift128+ step
	assign xs_a1  = word0_q ^ (word0_q << XS_A);
	assign xs_w0  = word1_q;
	assign xs_w1  = xs_a1 ^ word1_q ^ (xs_a1 >> XS_B) ^ (word1_q >> XS_C);
	assign xs_sum = xs_w1 + word1_q;

	// xoroshiro128+ step, output is the sum before the step
	assign xo_sum = word0_q + word1_q;
	assign xo_b1  = word1_q ^ word0_q;
	assign xo_w0  = {word0_q[WORD_W-1-XO_A:0], word0_q[WORD_W-1:WORD_W-XO_A]}
		^ xo_b1 ^ (xo_b1 << XO_B);
	assign xo_w1  = {xo_b1[WORD_W-1-XO_C:0], xo_b1[WORD_W-1:WORD_W-XO_C]};

	assign offset = {{(WORD_W-MIN_W){min_q[MIN_W-1]}}, min_q};

	// status back to the controller
	assign status.p_zero   = (possibilities == '0);
	assign status.div_last = (cnt_q == {CNT_W{1'b1}});
	assign status.reject   = (roll_q > ~rem_c_q);

	// generator state words, seed writes load them directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word0_q <= {{(WORD_W-1){1'b0}}, 1'b1};
			word1_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_SEED_LOW) begin
				word0_q <= cfg_data;
			end
			if (cfg_index == REG_SEED_HIGH) begin
				word1_q <= cfg_data;
			end
		end else if (cmd.gen_xs) begin
			word0_q <= xs_w0;
			word1_q <= xs_w1;
		end else if (cmd.gen_xo || cmd.draw) begin
			word0_q <= xo_w0;
			word1_q <= xo_w1;
		end
	end

	// step counter of the remainder units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.draw) begin
			cnt_q <= '0;
		end else if (cmd.div_run) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// request operands
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			poss_q <= possibilities;
			min_q  <= minimum;
		end
	end

	// remainder units: all-ones ceiling and the current roll, msb first
	always_ff @(posedge clk) begin
		if (cmd.draw) begin
			roll_q  <= xo_sum;
			rem_c_q <= '0;
			rem_r_q <= '0;
		end else if (cmd.div_run) begin
			rem_c_q <= rem_step(rem_c_q, 1'b1, poss_q);
			rem_r_q <= rem_step(rem_r_q, roll_q[~cnt_q], poss_q);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_sel)
				OSEL_XS: begin
					value_q <= xs_sum;
					bad_q   <= 1'b0;
				end
				OSEL_XO: begin
					value_q <= xo_sum;
					bad_q   <= 1'b0;
				end
				OSEL_ROLL: begin
					value_q <= rem_r_q + offset;
					bad_q   <= 1'b0;
				end
				OSEL_BAD: begin
					value_q <= '0;
					bad_q   <= 1'b1;
				end
				default: begin
					value_q <= '0;
					bad_q   <= 1'b0;
				end
			endcase
		end
	end

	assign value       = value_q;
	assign bad_request = bad_q;

endmodule

FILE: hdl/xoroshiro_xorshift_bounded_rng.sv
// ----------------------------------------------------------------------------
// xoroshiro_xorshift_bounded_rng: xorshift128+ / xoroshiro128+ bounded rng
// Two-word generator state seeded by register writes; draws from either
// generator or rolls a bounded value with rejection sampling.
//
//  channel  direction  handshake          payload
//  s        in         s_tvalid/s_tready  s_tdata, s_tuser (action)
//  m        out        m_tvalid/m_tready  m_tdata, m_tuser (bad_request)
//  cfg      in         cfg_we             cfg_index, cfg_data
//
// Generator draws, zero-possibility rolls and unused actions load the result register
// in the cycle they are accepted. A roll runs a draw, 64 remainder steps on the serial
// remainder units and a check; each rejected draw repeats the draw and the steps.
// Reset loads the state words with 1 and 0; no clearing pass is needed.
// A new transaction is taken only while the result register is empty or
// being drained; a stalled result holds the roll in its final check.
// ----------------------------------------------------------------------------
module xoroshiro_xorshift_bounded_rng
	import xbr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // possibilities [63:0], minimum [95:64]
	input  logic [1:0]  s_tuser,  // action [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // value [63:0]
	output logic        m_tuser,  // bad_request [0]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	xbr_cmd_t    cmd;
	xbr_status_t status;
	xbr_action_t action;

	assign action = xbr_action_t'(s_tuser);

	xbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.action   (action),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	xbr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.possibilities (s_tdata[WORD_W-1:0]),
		.minimum       (s_tdata[WORD_W+MIN_W-1:WORD_W]),
		.status        (status),
		.value         (m_tdata),
		.bad_request   (m_tuser)
	);

	// checks
	logic in_acc;
	logic roll_acc;
	assign in_acc   = s_tvalid && s_tready;
	assign roll_acc = in_acc && (s_tuser == ACT_ROLL) && (s_tdata[WORD_W-1:0] != '0);

	// a transaction is never taken while a held result is stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (!m_tvalid || m_tready))
		else $error("transaction accepted over a stalled result");

	// a flagged roll carries a zero value
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("bad request with nonzero value");

	// a valid roll needs the remainder pass before any result
	a_roll_latency: assert property (@(posedge clk) disable iff (!arst_n)
		roll_acc |=> !m_tvalid)
		else $error("roll result appeared too early");

	// every other transaction gives its result in the next cycle
	a_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !roll_acc) |=> m_tvalid)
		else $error("single cycle result missing");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for xoroshiro_xorshift_bounded_rng
// Walks a short table of directed requests and reseeds, then runs random phases
// of draws and bounded rolls, all but one under random stalls on both streams.
// Every result is compared in order against an in-bench generator model or a typed table entry.
// ----------------------------------------------------------------------------
module tb_top
	import xbr_pkg::*;
();

	localparam int          STALL_LIMIT  = 20000;
	localparam int          MAX_REPORTS  = 10;
	localparam int          PHASES       = 7;
	localparam int          PHASE_ITEMS  = 200;
	localparam logic [63:0] W_ZERO       = 64'h0;
	localparam logic [63:0] W_ONES       = '1;
	localparam logic [63:0] W_TOP        = 64'h8000_0000_0000_0000;
	localparam logic [63:0] W_TOP1       = 64'h8000_0000_0000_0001;
	localparam logic [31:0] MIN_NEG      = 32'h8000_0000;
	localparam logic [31:0] MIN_POS      = 32'h7fff_ffff;
	localparam logic [31:0] MIN_M1       = 32'hffff_ffff;

	// one result of the block
	typedef struct packed {
		logic [63:0] value;
		logic        bad;
	} draw_t;

	// directed row: either a reseed (p = seed_low) or a request
	typedef struct packed {
		logic        is_seed;
		xbr_action_t act;
		logic [63:0] p;
		logic [31:0] minv;
		logic [63:0] seed_hi;
		logic        typed;
		logic [63:0] exp_value;
		logic        exp_bad;
	} dir_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = ACT_XORSHIFT;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = REG_SEED_LOW;
	logic [63:0] cfg_data  = '0;

	// generator model state
	logic [63:0] gen_w0;
	logic [63:0] gen_w1;

	draw_t pending_draws[$];
	draw_t oldest_draw;
	bit    quiet_run    = 1'b0;
	int    errors       = 0;
	int    stall_cycles = 0;
	int    requests     = 0;
	int    rolls        = 0;
	int    zero_rolls   = 0;
	int    reseeds      = 0;
	int    results_seen = 0;

	dir_row_t directed_rows [25] = '{
		// out of reset: state words 1 and 0
		'{1'b0, ACT_XOROSHIRO, W_ZERO, 32'h0, W_ZERO, 1'b1, 64'h1, 1'b0},
		'{1'b0, ACT_ROLL, W_ZERO, MIN_M1, W_ZERO, 1'b1, W_ZERO, 1'b1},
		'{1'b0, ACT_NONE, W_ONES, MIN_M1, W_ZERO, 1'b1, W_ZERO, 1'b0},
		'{1'b0, ACT_XORSHIFT, W_ONES, MIN_M1, W_ZERO, 1'b0, W_ZERO, 1'b0},
		'{1'b0, ACT_XOROSHIRO, W_ZERO, 32'h0, W_ZERO, 1'b0, W_ZERO, 1'b0},
		// one outcome: remainder is always zero
		'{1'b0, ACT_ROLL, 64'h1, MIN_NEG, W_ZERO, 1'b1, 64'hffff_ffff_8000_0000, 1'b0},
		'{1'b0, ACT_ROLL, W_ONES, MIN_POS, W_ZERO, 1'b0, W_ZERO, 1'b0},
		// just above half range: about half the draws are rejected
		'{1'b0, ACT_ROLL, W_TOP1, 32'h0, W_ZERO, 1'b0, W_ZERO, 1'b0},
		'{1'b0, ACT_ROLL, W_TOP, MIN_M1, W_ZERO, 1'b0, W_ZERO, 1'b0},
		'{1'b0, ACT_ROLL, 64'h3, 32'h0, W_ZERO, 1'b0, W_ZERO, 1'b0},
		'{1'b0, ACT_ROLL, 64'h1_0000_0000, MIN_POS, W_ZERO, 1'b0, W_ZERO, 1'b0},
		'{1'b1, ACT_NONE, W_ONES, 32'h0, W_ONES, 1'b0, W_ZERO, 1'b0},
		'{1'b0, ACT_XORSHIFT, W_ZERO, 32'h0, W_ZERO, 1'b0, W_ZERO, 1'b0},
		'{1'b0, ACT_XOROSHIRO, W_ZERO, 32'h0, W_ZERO, 1'b0, W_ZERO, 1'b0},
		'{1'b0, ACT_ROLL, 64'h6, 32'h1, W_ZERO, 1'b0, W_ZERO, 1'b0},
		// all-zero state: generators stick at zero
		'{1'b1, ACT_NONE, W_ZERO, 32'h0, W_ZERO, 1'b0, W_ZERO, 1'b0},
		'{1'b0, ACT_XORSHIFT, W_ONES, MIN_M1, W_ZERO, 1'b1, W_ZERO, 1'b0},
		'{1'b0, ACT_XOROSHIRO, W_ONES, MIN_M1, W_ZERO, 1'b1, W_ZERO, 1'b0},
		'{1'b0, ACT_ROLL, 64'h5, 32'hffff_fffd, W_ZERO, 1'b1, 64'hffff_ffff_ffff_fffd, 1'b0},
		'{1'b0, ACT_ROLL, W_ONES, MIN_POS, W_ZERO, 1'b1, 64'h7fff_ffff, 1'b0},
		'{1'b0, ACT_NONE, W_ZERO, 32'h0, W_ZERO, 1'b1, W_ZERO, 1'b0},
		'{1'b1, ACT_NONE, 64'h0123_4567_89ab_cdef, 32'h0, 64'hfedc_ba98_7654_3210,
			1'b0, W_ZERO, 1'b0},
		'{1'b0, ACT_ROLL, W_ZERO, MIN_POS, W_ZERO, 1'b1, W_ZERO, 1'b1},
		'{1'b0, ACT_XOROSHIRO, W_ONES, MIN_NEG, W_ZERO, 1'b0, W_ZERO, 1'b0},
		'{1'b0, ACT_XORSHIFT, W_TOP, MIN_POS, W_ZERO, 1'b0, W_ZERO, 1'b0}
	};

	xoroshiro_xorshift_bounded_rng i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int k);
		rotl64 = (x << k) | (x >> (64 - k));
	endfunction

	// xorshift128+ step, returns the new high word plus the old one
	function automatic logic [63:0] xorshift_step();
		logic [63:0] a;
		logic [63:0] b;
		a = gen_w0;
		b = gen_w1;
		gen_w0 = b;
		a = a ^ (a << XS_A);
		gen_w1 = a ^ b ^ (a >> XS_B) ^ (b >> XS_C);
		xorshift_step = gen_w1 + b;
	endfunction

	// xoroshiro128+ step, returns the sum of the words before the step
	function automatic logic [63:0] xoroshiro_step();
		logic [63:0] a;
		logic [63:0] b;
		a = gen_w0;
		b = gen_w1;
		xoroshiro_step = a + b;
		b = b ^ a;
		gen_w0 = rotl64(a, XO_A) ^ b ^ (b << XO_B);
		gen_w1 = rotl64(b, XO_C);
	endfunction

	// expected result of one request, advancing the generator state
	function automatic draw_t compute_draw(input xbr_action_t act, input logic [63:0] poss,
			input logic [31:0] minv);
		draw_t       r;
		logic [63:0] accept_max;
		logic [63:0] roll;
		r = '0;
		case (act)
			ACT_XORSHIFT: begin
				r.value = xorshift_step();
			end
			ACT_XOROSHIRO: begin
				r.value = xoroshiro_step();
			end
			ACT_ROLL: begin
				if (poss == 64'h0) begin
					r.bad = 1'b1;
				end else begin
					// rejection sampling, bound is inclusive
					accept_max = poss * (W_ONES / poss);
					roll = xoroshiro_step();
					while (roll > accept_max) roll = xoroshiro_step();
					r.value = (roll % poss) + {{32{minv[31]}}, minv};
				end
			end
			default: begin
			end
		endcase
		compute_draw = r;
	endfunction

	// send one request, predict its result on acceptance
	task automatic issue_request(input xbr_action_t act, input logic [63:0] poss,
			input logic [31:0] minv, input bit typed, input draw_t typed_res);
		draw_t d;
		if (!quiet_run) begin
			while ($urandom_range(99) < 24) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {minv, poss};
		s_tuser  <= act;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		d = compute_draw(act, poss, minv);
		if (typed) d = typed_res;
		pending_draws.push_back(d);
		requests++;
		if (act == ACT_ROLL) begin
			rolls++;
			if (poss == 64'h0) zero_rolls++;
		end
	endtask

	// reload both seed registers once every result has drained
	task automatic load_seeds(input logic [63:0] lo, input logic [63:0] hi);
		s_tvalid <= 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SEED_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_SEED_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_w0 = lo;
		gen_w1 = hi;
		reseeds++;
	endtask

	// result side: check each transaction, then pick next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_draws.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("unexpected result: value %h bad %b", m_tdata, m_tuser);
					end
				end else begin
					oldest_draw = pending_draws.pop_front();
					if (m_tdata !== oldest_draw.value || m_tuser !== oldest_draw.bad) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("result %0d: expected value %h bad %b, got value %h bad %b",
								results_seen, oldest_draw.value, oldest_draw.bad,
								m_tdata, m_tuser);
						end
					end
				end
			end
			m_tready <= quiet_run || ($urandom_range(99) >= 24);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// stimulus
	initial begin
		dir_row_t    row;
		draw_t       typed_res;
		xbr_action_t act;
		logic [63:0] poss;
		logic [63:0] lo;
		logic [63:0] hi;
		int          pick;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		gen_w0 = 64'h1;
		gen_w1 = 64'h0;

		// directed table
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_seed) begin
				load_seeds(row.p, row.seed_hi);
			end else begin
				typed_res = '{value: row.exp_value, bad: row.exp_bad};
				issue_request(row.act, row.p, row.minv, row.typed, typed_res);
			end
		end

		// random phases, each on a fresh seed
		for (int ph = 0; ph < PHASES; ph++) begin
			lo = {$urandom, $urandom};
			hi = {$urandom, $urandom};
			case (ph)
				2: begin lo = W_ONES; hi = W_ZERO; end
				4: begin lo = W_ZERO; hi = W_ONES; end
				5: begin lo = 64'h1;  hi = W_ZERO; end
				default: begin end
			endcase
			load_seeds(lo, hi);
			quiet_run = (ph == 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				if (pick < 30)      act = ACT_XORSHIFT;
				else if (pick < 60) act = ACT_XOROSHIRO;
				else if (pick < 95) act = ACT_ROLL;
				else                act = ACT_NONE;
				case ($urandom_range(9))
					0:       poss = W_ZERO;
					1, 2:    poss = 64'($urandom_range(16, 1));
					3:       poss = W_ZERO | (64'h1 << $urandom_range(63));
					4:       poss = W_TOP + 64'($urandom_range(8, 1));
					5:       poss = W_ONES - 64'($urandom_range(7));
					default: poss = {$urandom, $urandom};
				endcase
				issue_request(act, poss, $urandom, 1'b0, '0);
			end
			quiet_run = 1'b0;
		end

		// drain
		s_tvalid <= 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (pending_draws.size() != 0) begin
			errors += pending_draws.size();
			$display("%0d results never arrived", pending_draws.size());
		end

		$display("covered %0d requests with %0d rolls (%0d with zero outcomes), %0d seed loads",
			requests, rolls, zero_rolls, reseeds);
		$display("checked %0d results, %0d mismatches", results_seen, errors);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
